// File: design/avs_pkg.sv
// shared constants and types for the altitude and velocity smoother
package avs_pkg;

  // default number of fractional bits of the smoothing factor
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int ALT_W  = 27;
  localparam int TIME_W = 32;
  localparam int VEL_W  = 23;

  // altitude difference, one bit wider than the altitude
  localparam int DIFF_W = ALT_W + 1;
  // magnitude of the altitude step times 1000
  localparam int NUM_W  = DIFF_W + 9;
  // signed raw velocity before smoothing
  localparam int RAW_W  = VEL_W + 1;

  // velocity saturation limit in mm/s
  localparam logic [NUM_W-1:0] VEL_LIMIT = NUM_W'(4000000);

  // stream word widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ALT,
    ST_DIV,
    ST_MUL_VEL,
    ST_DONE
  } avs_state_t;

endpackage

// File: design/avs_mul.sv
// bit-serial shift-add multiplier with round half up and a fractional shift
module avs_mul #(
  parameter int D_W  = avs_pkg::DIFF_W,
  parameter int FRAC = avs_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [D_W-1:0] mcand,
  input  logic [FRAC:0]         mplier,
  output logic                  done,
  output logic signed [D_W+1:0] step
);

  localparam int A_W   = FRAC + 1;
  localparam int CNT_W = $clog2(A_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [D_W-1:0] mcand_r;
  logic signed [D_W:0]   hi_r;
  logic [A_W-1:0]        lo_r;
  logic signed [D_W:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = lo_r[0] ? (hi_r + {mcand_r[D_W-1], mcand_r}) : hi_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(A_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product shifts right one bit a cycle, multiplier bits drop out below
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (busy_r) begin
      hi_r <= sum >>> 1;
      lo_r <= {sum[0], lo_r[A_W-1:1]};
    end
  end

  // floor((p + half) / 2^FRAC) = (p >>> FRAC) + p[FRAC-1]
  assign step = {hi_r, lo_r[A_W-1]} + (D_W+2)'(lo_r[A_W-2]);
  assign done = done_r;

endmodule

// File: design/avs_div.sv
// restoring divider, one quotient bit per cycle
module avs_div #(
  parameter int N_W = avs_pkg::NUM_W,
  parameter int D_W = avs_pkg::TIME_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   dvs_r;
  logic [D_W-1:0]   rem_r;
  logic [N_W-1:0]   q_r;
  logic [D_W+1:0]   diff;

  // trial subtract of the shifted remainder
  assign diff = {1'b0, rem_r, q_r[N_W-1]} - {2'b00, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      if (!diff[D_W+1]) begin
        rem_r <= diff[D_W-1:0];
        q_r   <= {q_r[N_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[D_W-2:0], q_r[N_W-1]};
        q_r   <= {q_r[N_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: design/altitude_velocity_smoother.sv
// altitude smoother with velocity estimate, serial multiply and divide
// one word in flight: each word passes the bit-serial multiplier for the altitude,
// the divider and the multiplier again for the velocity; when no time has elapsed
// only the altitude multiply runs, and the next word is taken once the result
// register is free
// reset: synchronous active low, clears estimates and timestamp, factor to ~0.1
module altitude_velocity_smoother #(
  parameter int FRAC_BITS = avs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // altitude_sample [26:0], sample_time [58:27]
  input  logic [avs_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // smoothed_altitude [26:0], smoothed_velocity [49:27]
  output logic [avs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // time_stalled [0]
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [FRAC_BITS:0]                  cfg_wr_data
);

  localparam int ALT_W  = avs_pkg::ALT_W;
  localparam int TIME_W = avs_pkg::TIME_W;
  localparam int VEL_W  = avs_pkg::VEL_W;
  localparam int DIFF_W = avs_pkg::DIFF_W;
  localparam int NUM_W  = avs_pkg::NUM_W;
  localparam int RAW_W  = avs_pkg::RAW_W;
  localparam int A_W    = FRAC_BITS + 1;
  localparam logic [A_W-1:0] ONE          = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [A_W-1:0] FACTOR_RESET = A_W'(((1 << FRAC_BITS) + 5) / 10);

  avs_pkg::avs_state_t state_r, state_nxt;

  logic [A_W-1:0]           factor_r;
  logic [A_W-1:0]           a_r;
  logic signed [ALT_W-1:0]  alt_est_r;
  logic signed [VEL_W-1:0]  vel_est_r;
  logic [TIME_W-1:0]        prev_time_r;
  logic [TIME_W-1:0]        dt_r;
  logic                     stalled_r;
  logic signed [ALT_W-1:0]  new_alt_r;
  logic signed [VEL_W-1:0]  new_vel_r;
  logic                     neg_r;
  logic [ALT_W+VEL_W-1:0]   out_data_r;
  logic                     out_user_r;
  logic                     out_valid_r;

  logic signed [ALT_W-1:0]  sample;
  logic [TIME_W-1:0]        now;
  logic                     in_acc;
  logic [A_W-1:0]           a_lim;
  logic [A_W-1:0]           mul_mplier;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [DIFF_W-1:0] mul_mcand;
  logic signed [DIFF_W+1:0] mul_step;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         quot;
  logic signed [DIFF_W-1:0] d_alt;
  logic signed [ALT_W-1:0]  new_alt;
  logic signed [DIFF_W-1:0] delta;
  logic signed [NUM_W:0]    delta_x;
  logic signed [NUM_W:0]    num;
  logic [NUM_W:0]           num_abs;
  logic [NUM_W-1:0]         mag_sat;
  logic signed [RAW_W-1:0]  raw;
  logic signed [RAW_W:0]    d_vel;
  logic signed [VEL_W-1:0]  new_vel;
  logic                     out_free;

  // input word fields
  assign sample = in_tdata[ALT_W-1:0];
  assign now    = in_tdata[ALT_W +: TIME_W];
  assign in_acc = in_tvalid && in_tready;

  // factor above one acts as one
  assign a_lim = (factor_r > ONE) ? ONE : factor_r;

  // altitude error against the current estimate
  assign d_alt   = {sample[ALT_W-1], sample} - {alt_est_r[ALT_W-1], alt_est_r};
  assign new_alt = ALT_W'(alt_est_r + mul_step);
  assign delta   = {new_alt[ALT_W-1], new_alt} - {alt_est_r[ALT_W-1], alt_est_r};

  // times 1000 as 1024 - 16 - 8
  assign delta_x = (NUM_W+1)'(delta);
  assign num     = (delta_x <<< 10) - (delta_x <<< 4) - (delta_x <<< 3);
  assign num_abs = num[NUM_W] ? (NUM_W+1)'(-num) : num;

  // saturate the raw velocity and restore its sign
  assign mag_sat = (quot > avs_pkg::VEL_LIMIT) ? avs_pkg::VEL_LIMIT : quot;
  assign raw     = neg_r ? -RAW_W'(mag_sat) : RAW_W'(mag_sat);
  assign d_vel   = {raw[RAW_W-1], raw} - (RAW_W+1)'(vel_est_r);
  assign new_vel = VEL_W'(vel_est_r + mul_step);

  // the multiplier sees the altitude error first, the velocity error second
  assign mul_mcand  = (state_r == avs_pkg::ST_IDLE) ? d_alt : DIFF_W'(d_vel);
  assign mul_mplier = (state_r == avs_pkg::ST_IDLE) ? a_lim : a_r;

  assign out_free = !out_valid_r || out_tready;

  avs_mul #(
    .D_W  (DIFF_W),
    .FRAC (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .step   (mul_step)
  );

  avs_div #(
    .N_W (NUM_W),
    .D_W (TIME_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_abs[NUM_W-1:0]),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= avs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit strobes
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      avs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mul_start = 1'b1;
          state_nxt = avs_pkg::ST_MUL_ALT;
        end
      end
      avs_pkg::ST_MUL_ALT: begin
        if (mul_done) begin
          if (stalled_r) begin
            state_nxt = avs_pkg::ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = avs_pkg::ST_DIV;
          end
        end
      end
      avs_pkg::ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = avs_pkg::ST_MUL_VEL;
        end
      end
      avs_pkg::ST_MUL_VEL: begin
        if (mul_done) begin
          state_nxt = avs_pkg::ST_DONE;
        end
      end
      avs_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = avs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = avs_pkg::ST_IDLE;
      end
    endcase
  end

  // factor register and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r    <= FACTOR_RESET;
      alt_est_r   <= '0;
      vel_est_r   <= '0;
      prev_time_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        factor_r <= cfg_wr_data;
      end
      if (in_acc) begin
        prev_time_r <= now;
      end
      if (state_r == avs_pkg::ST_DONE && out_free) begin
        alt_est_r <= new_alt_r;
        if (!stalled_r) begin
          vel_est_r <= new_vel_r;
        end
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r       <= a_lim;
      dt_r      <= now - prev_time_r;
      stalled_r <= (now == prev_time_r);
    end
    if (state_r == avs_pkg::ST_MUL_ALT && mul_done) begin
      new_alt_r <= new_alt;
      neg_r     <= num[NUM_W];
    end
    if (state_r == avs_pkg::ST_MUL_VEL && mul_done) begin
      new_vel_r <= new_vel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == avs_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == avs_pkg::ST_DONE && out_free) begin
      out_data_r <= {(stalled_r ? vel_est_r : new_vel_r), new_alt_r};
      out_user_r <= stalled_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(avs_pkg::OUT_DATA_W - ALT_W - VEL_W){1'b0}}, out_data_r};
  assign out_tuser  = out_user_r;

endmodule

// File: design/avs_checker.sv
// port-level checks for the altitude and velocity smoother
module avs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [avs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  localparam int VEL_LO = avs_pkg::ALT_W;
  localparam int VEL_HI = avs_pkg::ALT_W + avs_pkg::VEL_W - 1;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one word at a time: no second word right after an accepted one
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // velocity never leaves the saturation range
  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[VEL_HI:VEL_LO]) <= 23'sd4000000) &&
                   ($signed(out_tdata[VEL_HI:VEL_LO]) >= -23'sd4000000))
    else $error("velocity outside saturation range");

endmodule

bind altitude_velocity_smoother avs_checker u_avs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
